// ----- rtl/pett_pkg.sv -----
// Shared types and constants of the periodic event timer table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pett_pkg;

   localparam int ENTRIES_DEF   = 16;
   localparam int ID_BITS_DEF   = 16;
   localparam int TYPE_BITS_DEF = 8;
   localparam int MAX_COUNT     = 32767;

   typedef enum logic [2:0] {
      CMD_ADD      = 3'd0,
      CMD_RM_TYPE  = 3'd1,
      CMD_RM_ID    = 3'd2,
      CMD_RM_IDINT = 3'd3,
      CMD_TICK     = 3'd4,
      CMD_CLEAR    = 3'd5
   } cmd_type;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [15:0]        event_id;
      logic [7:0]         event_type;
      logic [31:0]        interval_ms;
      logic signed [15:0] repeat_count;
      logic signed [15:0] ref_delta;
      logic [31:0]        elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] fired_id;
      logic [1:0]  status;
      logic [31:0] next_wait_ms;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/pett_store.sv -----
// Slot storage of the timer table: one write port, one read port, registered read.
// Depends on pett_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pett_store
   import pett_pkg::*;
#(
   parameter int DEPTH = ENTRIES_DEF,
   parameter int WIDTH = 119
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/periodic_event_timer_table.sv -----
// Top level of the periodic event timer table: sequencer and slot walk.
// Depends on pett_pkg and pett_store.
//
//  channel  ports               direction  carries
//  req      req_valid/req_stall  in         one command item (req_type)
//  rsp      rsp_valid/rsp_stall  out        ack, fired or tick-done items (rsp_type)
//
// A command walks the n live slots, then finishes; clear and rejected items skip the walk.
// Unstalled, the walk reads one slot a cycle from the store port and compacts in place.
// Reset empties the table at once (fill count), no clearing pass.
// A stalled rsp holds the walk at the slot that fires; req_stall is high while busy.
`timescale 1ns / 1ps
`default_nettype none
module periodic_event_timer_table
   import pett_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int ID_BITS   = ID_BITS_DEF,
   parameter int TYPE_BITS = TYPE_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1) > IW ? $clog2(ENTRIES + 1) : IW;
   localparam int RF_LO = 0;
   localparam int RP_LO = 15;
   localparam int RM_LO = 31;
   localparam int IV_LO = 63;
   localparam int TY_LO = 95;
   localparam int ID_LO = 95 + TYPE_BITS;
   localparam int EW    = ID_LO + ID_BITS;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CW-1:0] n_ff, n_in, wr_ff, wr_in;
   logic [IW-1:0] rd_ff, rd_in, raddr;
   logic          found_ff, found_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   wait_ff, wait_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          we;
   logic [EW-1:0] wdata, rdata_ff;

   logic [ID_BITS-1:0]   e_id, k_id, n_id;
   logic [TYPE_BITS-1:0] e_ty, k_ty;
   logic [31:0]          e_iv, e_rm, n_rm;
   logic signed [15:0]   e_rp, n_rp;
   logic [14:0]          e_rf, n_rf;
   logic [ID_BITS+15:0]  id_ext, fid_ext;
   logic [TYPE_BITS+7:0] ty_ext;
   logic                 keep, emit, release_it, out_free, last_slot;
   logic [15:0]          rf_sum;
   logic signed [16:0]   rp_sum;
   logic [16:0]          rf_diff;
   logic [CW-1:0]        rd_plus;

   pett_store #(.DEPTH(ENTRIES), .WIDTH(EW)) u_store (
      .clock(clock), .we(we), .waddr(wr_ff[IW-1:0]), .wdata(wdata),
      .raddr(raddr), .rdata_ff(rdata_ff)
   );

   assign e_id = rdata_ff[ID_LO +: ID_BITS];
   assign e_ty = rdata_ff[TY_LO +: TYPE_BITS];
   assign e_iv = rdata_ff[IV_LO +: 32];
   assign e_rm = rdata_ff[RM_LO +: 32];
   assign e_rp = rdata_ff[RP_LO +: 16];
   assign e_rf = rdata_ff[RF_LO +: 15];

   assign id_ext  = {{ID_BITS{1'b0}}, req_ff.event_id};
   assign k_id    = id_ext[ID_BITS-1:0];
   assign ty_ext  = {{TYPE_BITS{1'b0}}, req_ff.event_type};
   assign k_ty    = ty_ext[TYPE_BITS-1:0];
   assign fid_ext = {16'd0, e_id};

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_plus   = CW'(rd_ff) + CW'(1);
   assign last_slot = rd_plus == n_ff;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      wr_ff     <= wr_in;
      rd_ff     <= rd_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      wait_ff   <= wait_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      n_in         = n_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      raddr        = rd_ff;
      we           = 1'b0;
      wdata        = rdata_ff;

      // per-slot update
      n_id       = e_id;
      n_rm       = e_rm;
      n_rp       = e_rp;
      n_rf       = e_rf;
      keep       = 1'b1;
      emit       = 1'b0;
      release_it = 1'b0;
      rf_sum     = {1'b0, e_rf} + req_ff.ref_delta[14:0];
      rp_sum     = {e_rp[15], e_rp} + {req_ff.repeat_count[15], req_ff.repeat_count};
      rf_diff    = {2'b00, e_rf} - {1'b0, req_ff.ref_delta};
      case (req_ff.cmd)
         CMD_ADD: begin
            if (req_ff.ref_delta != 16'sd0 && !found_ff && e_id == k_id
                && e_iv == req_ff.interval_ms) begin
               found_in = 1'b1;
               n_rf = rf_sum[15] ? 15'(MAX_COUNT) : rf_sum[14:0];
               if (e_rp != -16'sd1) begin
                  if (req_ff.repeat_count == -16'sd1) begin
                     n_rp = -16'sd1;
                  end else if (rp_sum > 17'sd32767) begin
                     n_rp = 16'(MAX_COUNT);
                  end else begin
                     n_rp = rp_sum[15:0];
                  end
               end
            end
         end
         CMD_RM_TYPE: begin
            release_it = e_ty == k_ty;
         end
         CMD_RM_ID: begin
            release_it = !found_ff && e_id == k_id;
         end
         CMD_RM_IDINT: begin
            release_it = !found_ff && e_id == k_id && e_iv == req_ff.interval_ms;
         end
         CMD_TICK: begin
            if (e_rp == 16'sd0) begin
               keep = 1'b0;
            end else if (e_rm <= req_ff.elapsed_ms) begin
               emit = 1'b1;
               n_rm = e_iv;
               if (e_rp > 16'sd0) begin
                  n_rp = e_rp - 16'sd1;
               end
            end else begin
               n_rm = e_rm - req_ff.elapsed_ms;
            end
         end
         default: begin
         end
      endcase
      if (release_it) begin
         if (req_ff.cmd != CMD_RM_TYPE) begin
            found_in = 1'b1;
         end
         if (req_ff.ref_delta == 16'sd0 || rf_diff[16] || rf_diff == 17'd0) begin
            keep = 1'b0;
         end else begin
            n_rf = rf_diff[14:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            raddr = '0;
            if (req_valid) begin
               req_in    = req_data;
               rd_in     = '0;
               wr_in     = '0;
               found_in  = 1'b0;
               wait_in   = '0;
               status_in = STAT_OK;
               state_in  = n_ff != '0 ? ST_WALK : ST_FIN;
               case (req_data.cmd)
                  CMD_ADD: begin
                     if (req_data.ref_delta[15] || !(req_data.repeat_count == -16'sd1
                         || req_data.repeat_count > 16'sd0)) begin
                        status_in = STAT_INVALID;
                        wr_in     = n_ff;
                        state_in  = ST_FIN;
                     end
                  end
                  CMD_RM_TYPE, CMD_RM_ID, CMD_RM_IDINT: begin
                     if (req_data.ref_delta[15]) begin
                        status_in = STAT_INVALID;
                        wr_in     = n_ff;
                        state_in  = ST_FIN;
                     end
                  end
                  CMD_TICK: begin
                  end
                  CMD_CLEAR: begin
                     state_in = ST_FIN;
                  end
                  default: begin
                     status_in = STAT_INVALID;
                     wr_in     = n_ff;
                     state_in  = ST_FIN;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (emit && !out_free) begin
               raddr = rd_ff;
            end else begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{kind: KIND_FIRED, fired_id: fid_ext[15:0], status: STAT_OK,
                             next_wait_ms: 32'd0, last: 1'b0};
               end
               if (keep) begin
                  we    = 1'b1;
                  wdata = {n_id, e_ty, e_iv, n_rm, n_rp, n_rf};
                  wr_in = wr_ff + CW'(1);
                  if (n_rm != 32'd0 && (wait_ff == 32'd0 || n_rm < wait_ff)) begin
                     wait_in = n_rm;
                  end
               end
               rd_in = rd_ff + IW'(1);
               raddr = rd_ff + IW'(1);
               if (last_slot) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               n_in         = wr_ff;
               state_in     = ST_IDLE;
               if (req_ff.cmd == CMD_TICK) begin
                  rsp_in = '{kind: KIND_DONE, fired_id: 16'd0, status: STAT_OK,
                             next_wait_ms: wait_ff, last: 1'b1};
               end else begin
                  rsp_in = '{kind: KIND_ACK, fired_id: 16'd0, status: status_ff,
                             next_wait_ms: 32'd0, last: 1'b1};
                  if (req_ff.cmd == CMD_ADD && status_ff == STAT_OK && !found_ff) begin
                     if (wr_ff == CW'(ENTRIES)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        we    = 1'b1;
                        wdata = {k_id, k_ty, req_ff.interval_ms, req_ff.interval_ms,
                                 req_ff.repeat_count,
                                 req_ff.ref_delta == 16'sd0 ? 15'd1
                                                            : req_ff.ref_delta[14:0]};
                        n_in  = wr_ff + CW'(1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire
